// ===== src/gaps_pkg.sv =====
// Shared types, constants and helpers for the grid path search block.
// No dependencies.
`default_nettype none
package gaps_pkg;

  localparam int GRID_SIZE = 16;
  localparam int COORD_W   = $clog2(GRID_SIZE);
  localparam int CELL_W    = 2 * COORD_W;
  localparam int CELLS     = GRID_SIZE * GRID_SIZE;
  localparam int COST_W    = 19;

  localparam logic [COST_W-1:0] COST_STRAIGHT = COST_W'(1000);
  localparam logic [COST_W-1:0] COST_DIAGONAL = COST_W'(1414);
  localparam logic [COST_W-1:0] COST_UNIT     = COST_W'(1000);

  // operation codes
  localparam logic [1:0] OP_MARK   = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // per-cell search state
  localparam logic [1:0] ST_NONE   = 2'd0;
  localparam logic [1:0] ST_OPEN   = 2'd1;
  localparam logic [1:0] ST_CLOSED = 2'd2;

  // neighbor offset codes: 0 is -1, 1 is 0, 2 is +1
  localparam logic [1:0] D_NEG  = 2'd0;
  localparam logic [1:0] D_ZERO = 2'd1;
  localparam logic [1:0] D_POS  = 2'd2;

  typedef struct packed {
    logic [COST_W-1:0] g;
    logic [COST_W-1:0] f;
    logic [CELL_W-1:0] parent;
    logic [CELL_W-1:0] rank;
  } node_t;

  typedef struct packed {
    logic [1:0] dx;
    logic [1:0] dz;
  } delta_t;

  typedef struct packed {
    logic [COST_W-1:0]  g_cur;
    logic               diag;
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] nz;
    logic [COORD_W-1:0] gx;
    logic [COORD_W-1:0] gz;
  } cost_req_t;

  typedef struct packed {
    logic [COST_W-1:0] ng;
    logic [COST_W-1:0] hc;
    logic [COST_W-1:0] g_old;
  } cost_cmp_t;

  // neighbor visiting order: dx outer, dz inner, center skipped
  function automatic delta_t gaps_delta(input logic [2:0] d);
    delta_t r;
    unique case (d)
      3'd0: r = '{dx: D_NEG,  dz: D_NEG};
      3'd1: r = '{dx: D_NEG,  dz: D_ZERO};
      3'd2: r = '{dx: D_NEG,  dz: D_POS};
      3'd3: r = '{dx: D_ZERO, dz: D_NEG};
      3'd4: r = '{dx: D_ZERO, dz: D_POS};
      3'd5: r = '{dx: D_POS,  dz: D_NEG};
      3'd6: r = '{dx: D_POS,  dz: D_ZERO};
      3'd7: r = '{dx: D_POS,  dz: D_POS};
      default: r = '{dx: D_ZERO, dz: D_ZERO};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/gaps_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`default_nettype none
module gaps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wa,
  input  wire logic [WIDTH-1:0]         wd,
  input  wire logic [$clog2(DEPTH)-1:0] ra,
  output logic      [WIDTH-1:0]         rq
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rq <= mem[ra];
  end

endmodule
`default_nettype wire

// ===== src/gaps_cost.sv =====
// Shared cost unit: step cost, heuristic, estimate and improvement compare.
// Depends on gaps_pkg.
`default_nettype none
module gaps_cost
  import gaps_pkg::*;
(
  input  wire cost_req_t         req,
  input  wire cost_cmp_t         cmp,
  output logic [COST_W-1:0]      ng,
  output logic [COST_W-1:0]      hc,
  output logic [COST_W-1:0]      nf,
  output logic                   better
);

  logic [COORD_W-1:0] adx, adz;
  logic [COORD_W:0]   h;

  always_comb begin
    adx = (req.nx > req.gx) ? req.nx - req.gx : req.gx - req.nx;
    adz = (req.nz > req.gz) ? req.nz - req.gz : req.gz - req.nz;
    h   = {1'b0, adx} + {1'b0, adz};
    ng  = req.g_cur + (req.diag ? COST_DIAGONAL : COST_STRAIGHT);
    hc  = COST_W'(h) * COST_UNIT;
    // second half, in the next cycle, on registered ng/hc
    nf     = cmp.ng + cmp.hc;
    better = cmp.ng < cmp.g_old;
  end

endmodule
`default_nettype wire

// ===== src/grid_astar_path_search.sv =====
// Grid path search top level: sequencer, cell stores, open list and path.
// Depends on gaps_pkg, gaps_ram and gaps_cost.
//
// 8-connected A* over a 16 x 16 obstacle grid. One word in gives one word
// out. After reset the blocked map is swept clear with in_ready low. Mark
// writes one cell per cycle. Search starts with a sweep of the per-cell
// state, then each expansion makes a linear pass over the open list (one
// list entry per cycle through the node memory read port), a pop and a
// visit of the eight neighbors through the shared cost unit; the found
// path is then walked twice. The open list scan dominates a search.
// in_ready is high only when the sequencer is idle; a finished result
// sits in the output register, so the next word can be taken while the
// previous result waits for out_ready.
`default_nettype none
module grid_astar_path_search
  import gaps_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_operation,
  input  wire logic [3:0]         in_rect_x_lo,
  input  wire logic [3:0]         in_rect_z_lo,
  input  wire logic [3:0]         in_rect_x_hi,
  input  wire logic [3:0]         in_rect_z_hi,
  input  wire logic               in_mark_blocked,
  input  wire logic [3:0]         in_start_x,
  input  wire logic [3:0]         in_start_z,
  input  wire logic [3:0]         in_goal_x,
  input  wire logic [3:0]         in_goal_z,
  input  wire logic [7:0]         in_path_index,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_path_found,
  output logic [8:0]              out_path_length,
  output logic [3:0]              out_cell_x,
  output logic [3:0]              out_cell_z,
  output logic                    out_index_valid
);

  typedef enum logic [17:0] {
    S_INIT   = 18'h00001,
    S_IDLE   = 18'h00002,
    S_MARK   = 18'h00004,
    S_CLR    = 18'h00008,
    S_GCHK   = 18'h00010,
    S_GWAIT  = 18'h00020,
    S_POPCHK = 18'h00040,
    S_SCAN   = 18'h00080,
    S_POPRM  = 18'h00100,
    S_POPWR  = 18'h00200,
    S_NBRD   = 18'h00400,
    S_NBEV   = 18'h00800,
    S_W1CHK  = 18'h01000,
    S_W1GET  = 18'h02000,
    S_W2PUT  = 18'h04000,
    S_W2GET  = 18'h08000,
    S_RDWT   = 18'h10000,
    S_RESP   = 18'h20000
  } state_t;

  localparam int CNT_W = CELL_W + 1;

  // control
  state_t             state_r, state_nxt;
  logic [CELL_W-1:0]  sweep_r, sweep_nxt;
  logic               found_r, found_nxt;
  logic [CNT_W-1:0]   len_r, len_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CELL_W-1:0]  rank_r, rank_nxt;
  logic [CNT_W-1:0]   scan_i_r, scan_i_nxt;
  logic               s1_v_r, s1_v_nxt, s2_v_r, s2_v_nxt;
  logic               best_v_r, best_v_nxt;
  logic [2:0]         dir_r, dir_nxt;
  logic               out_valid_r, out_valid_nxt;

  // data
  logic [COORD_W-1:0] zl_r, zl_nxt, xh_r, xh_nxt, zh_r, zh_nxt;
  logic [COORD_W-1:0] mx_r, mx_nxt, mz_r, mz_nxt;
  logic               mval_r, mval_nxt;
  logic [COORD_W-1:0] sx_r, sx_nxt, sz_r, sz_nxt, gx_r, gx_nxt, gz_r, gz_nxt;
  logic [CELL_W-1:0]  s1_pos_r, s1_pos_nxt, s2_pos_r, s2_pos_nxt;
  logic [CELL_W-1:0]  s2_cell_r, s2_cell_nxt;
  logic [CELL_W-1:0]  best_pos_r, best_pos_nxt, best_cell_r, best_cell_nxt;
  logic [COST_W-1:0]  best_f_r, best_f_nxt, best_g_r, best_g_nxt;
  logic [CELL_W-1:0]  best_rank_r, best_rank_nxt;
  logic [CELL_W-1:0]  nb_r, nb_nxt;
  logic [COST_W-1:0]  ng_r, ng_nxt, hc_r, hc_nxt;
  logic [CELL_W-1:0]  p_r, p_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt, wi_r, wi_nxt;
  logic [CELL_W-1:0]  res_cell_r, res_cell_nxt;
  logic               res_valid_r, res_valid_nxt;
  logic               o_found_r, o_found_nxt;
  logic [CNT_W-1:0]   o_len_r, o_len_nxt;
  logic [CELL_W-1:0]  o_cell_r, o_cell_nxt;
  logic               o_ivalid_r, o_ivalid_nxt;

  // memory ports
  logic               blk_we, st_we, node_we, heap_we, path_we;
  logic [CELL_W-1:0]  blk_wa, st_wa, node_wa, heap_wa, path_wa;
  logic [CELL_W-1:0]  blk_ra, st_ra, node_ra, heap_ra, path_ra;
  logic               blk_wd, blk_q;
  logic [1:0]         st_wd, st_q;
  node_t              node_wd, node_q;
  logic [CELL_W-1:0]  heap_wd, heap_q, path_wd, path_q;

  // neighbor geometry
  delta_t             dlt;
  logic [COORD_W:0]   nx_w, nz_w;
  logic               nb_ok;
  logic [CELL_W-1:0]  nb_cell;
  logic [CELL_W-1:0]  start_cell, goal_cell;

  cost_req_t          creq;
  cost_cmp_t          ccmp;
  logic [COST_W-1:0]  c_ng, c_hc, c_nf;
  logic               c_better;

  gaps_ram #(.WIDTH(1), .DEPTH(CELLS)) u_blk (
    .clk(clk), .we(blk_we), .wa(blk_wa), .wd(blk_wd), .ra(blk_ra), .rq(blk_q));
  gaps_ram #(.WIDTH(2), .DEPTH(CELLS)) u_state (
    .clk(clk), .we(st_we), .wa(st_wa), .wd(st_wd), .ra(st_ra), .rq(st_q));
  gaps_ram #(.WIDTH($bits(node_t)), .DEPTH(CELLS)) u_node (
    .clk(clk), .we(node_we), .wa(node_wa), .wd(node_wd), .ra(node_ra), .rq(node_q));
  gaps_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_heap (
    .clk(clk), .we(heap_we), .wa(heap_wa), .wd(heap_wd), .ra(heap_ra), .rq(heap_q));
  gaps_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_path (
    .clk(clk), .we(path_we), .wa(path_wa), .wd(path_wd), .ra(path_ra), .rq(path_q));

  gaps_cost u_cost (
    .req(creq), .cmp(ccmp), .ng(c_ng), .hc(c_hc), .nf(c_nf), .better(c_better));

  assign start_cell = {sz_r, sx_r};
  assign goal_cell  = {gz_r, gx_r};

  // neighbor of the current cell; bit COORD_W set means off the grid
  always_comb begin
    dlt     = gaps_delta(dir_r);
    nx_w    = {1'b0, best_cell_r[COORD_W-1:0]} + {{(COORD_W-1){1'b0}}, dlt.dx}
              - {{COORD_W{1'b0}}, 1'b1};
    nz_w    = {1'b0, best_cell_r[CELL_W-1:COORD_W]} + {{(COORD_W-1){1'b0}}, dlt.dz}
              - {{COORD_W{1'b0}}, 1'b1};
    nb_ok   = !nx_w[COORD_W] && !nz_w[COORD_W];
    nb_cell = {nz_w[COORD_W-1:0], nx_w[COORD_W-1:0]};
    creq    = '{g_cur: best_g_r, diag: (dlt.dx != D_ZERO) && (dlt.dz != D_ZERO),
                nx: nx_w[COORD_W-1:0], nz: nz_w[COORD_W-1:0], gx: gx_r, gz: gz_r};
    ccmp    = '{ng: ng_r, hc: hc_r, g_old: node_q.g};
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    logic scan_issue;
    logic scan_take;

    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    found_nxt     = found_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    rank_nxt      = rank_r;
    scan_i_nxt    = scan_i_r;
    s1_v_nxt      = s1_v_r;
    s2_v_nxt      = s2_v_r;
    best_v_nxt    = best_v_r;
    dir_nxt       = dir_r;
    out_valid_nxt = out_valid_r && !out_ready;
    zl_nxt = zl_r; xh_nxt = xh_r; zh_nxt = zh_r;
    mx_nxt = mx_r; mz_nxt = mz_r; mval_nxt = mval_r;
    sx_nxt = sx_r; sz_nxt = sz_r; gx_nxt = gx_r; gz_nxt = gz_r;
    s1_pos_nxt = s1_pos_r; s2_pos_nxt = s2_pos_r; s2_cell_nxt = s2_cell_r;
    best_pos_nxt = best_pos_r; best_cell_nxt = best_cell_r;
    best_f_nxt = best_f_r; best_g_nxt = best_g_r; best_rank_nxt = best_rank_r;
    nb_nxt = nb_r; ng_nxt = ng_r; hc_nxt = hc_r;
    p_nxt = p_r; n_nxt = n_r; wi_nxt = wi_r;
    res_cell_nxt = res_cell_r; res_valid_nxt = res_valid_r;
    o_found_nxt = o_found_r; o_len_nxt = o_len_r;
    o_cell_nxt = o_cell_r; o_ivalid_nxt = o_ivalid_r;

    blk_we  = 1'b0; blk_wa  = '0; blk_wd  = 1'b0; blk_ra  = nb_cell;
    st_we   = 1'b0; st_wa   = '0; st_wd   = ST_NONE; st_ra = nb_cell;
    node_we = 1'b0; node_wa = '0; node_wd = '0; node_ra = nb_cell;
    heap_we = 1'b0; heap_wa = '0; heap_wd = '0; heap_ra = scan_i_r[CELL_W-1:0];
    path_we = 1'b0; path_wa = '0; path_wd = '0; path_ra = in_path_index;

    scan_issue = scan_i_r < cnt_r;
    scan_take  = 1'b0;

    unique case (state_r)
      S_INIT: begin
        blk_we    = 1'b1;
        blk_wa    = sweep_r;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == CELL_W'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          res_valid_nxt = 1'b0;
          res_cell_nxt  = '0;
          unique case (in_operation)
            OP_MARK: begin
              zl_nxt = in_rect_z_lo;
              xh_nxt = in_rect_x_hi; zh_nxt = in_rect_z_hi;
              mx_nxt = in_rect_x_lo; mz_nxt = in_rect_z_lo;
              mval_nxt = in_mark_blocked;
              if (in_rect_x_lo > in_rect_x_hi || in_rect_z_lo > in_rect_z_hi) begin
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_MARK;
              end
            end
            OP_SEARCH: begin
              // endpoints are 4 bits on a 16-wide grid, so no clamp is needed
              sx_nxt = in_start_x; sz_nxt = in_start_z;
              gx_nxt = in_goal_x;  gz_nxt = in_goal_z;
              found_nxt = 1'b0;
              len_nxt   = '0;
              cnt_nxt   = '0;
              sweep_nxt = '0;
              state_nxt = S_CLR;
            end
            OP_READ: begin
              if ({1'b0, in_path_index} < len_r) begin
                state_nxt = S_RDWT;
              end else begin
                state_nxt = S_RESP;
              end
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end

      S_MARK: begin
        blk_we = 1'b1;
        blk_wa = {mz_r, mx_r};
        blk_wd = mval_r;
        if (mz_r == zh_r) begin
          if (mx_r == xh_r) begin
            state_nxt = S_RESP;
          end else begin
            mx_nxt = mx_r + 1'b1;
            mz_nxt = zl_r;
          end
        end else begin
          mz_nxt = mz_r + 1'b1;
        end
      end

      S_CLR: begin
        st_we     = 1'b1;
        st_wa     = sweep_r;
        st_wd     = ST_NONE;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == CELL_W'(CELLS - 1)) begin
          state_nxt = S_GCHK;
        end
      end

      S_GCHK: begin
        blk_ra = goal_cell;
        if (start_cell == goal_cell) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_GWAIT;
        end
      end

      S_GWAIT: begin
        if (blk_q) begin
          state_nxt = S_RESP;
        end else begin
          st_we   = 1'b1; st_wa = start_cell; st_wd = ST_OPEN;
          node_we = 1'b1; node_wa = start_cell;
          node_wd = '{g: '0, f: '0, parent: start_cell, rank: '0};
          heap_we = 1'b1; heap_wa = '0; heap_wd = start_cell;
          cnt_nxt  = CNT_W'(1);
          rank_nxt = CELL_W'(1);
          state_nxt = S_POPCHK;
        end
      end

      S_POPCHK: begin
        if (cnt_r == '0) begin
          state_nxt = S_RESP;
        end else begin
          scan_i_nxt = '0;
          s1_v_nxt   = 1'b0;
          s2_v_nxt   = 1'b0;
          best_v_nxt = 1'b0;
          state_nxt  = S_SCAN;
        end
      end

      // three-deep pipe: list read, node read, compare
      S_SCAN: begin
        heap_ra     = scan_i_r[CELL_W-1:0];
        s1_v_nxt    = scan_issue;
        s1_pos_nxt  = scan_i_r[CELL_W-1:0];
        scan_i_nxt  = scan_i_r + CNT_W'(scan_issue);
        node_ra     = heap_q;
        s2_v_nxt    = s1_v_r;
        s2_pos_nxt  = s1_pos_r;
        s2_cell_nxt = heap_q;
        if (s2_v_r) begin
          scan_take = !best_v_r || (node_q.f < best_f_r) ||
                      ((node_q.f == best_f_r) && (node_q.rank < best_rank_r));
        end
        if (scan_take) begin
          best_v_nxt    = 1'b1;
          best_pos_nxt  = s2_pos_r;
          best_cell_nxt = s2_cell_r;
          best_f_nxt    = node_q.f;
          best_g_nxt    = node_q.g;
          best_rank_nxt = node_q.rank;
        end
        if (!scan_issue && !s1_v_r && !s2_v_r) begin
          state_nxt = S_POPRM;
        end
      end

      S_POPRM: begin
        cnt_nxt   = cnt_r - 1'b1;
        heap_ra   = CELL_W'(cnt_r - 1'b1);
        state_nxt = S_POPWR;
      end

      S_POPWR: begin
        // last list entry moves into the popped slot
        heap_we = 1'b1;
        heap_wa = best_pos_r;
        heap_wd = heap_q;
        if (best_cell_r == goal_cell) begin
          p_nxt     = best_cell_r;
          n_nxt     = CNT_W'(1);
          state_nxt = S_W1CHK;
        end else begin
          st_we     = 1'b1;
          st_wa     = best_cell_r;
          st_wd     = ST_CLOSED;
          dir_nxt   = '0;
          state_nxt = S_NBRD;
        end
      end

      S_NBRD: begin
        if (nb_ok) begin
          nb_nxt    = nb_cell;
          ng_nxt    = c_ng;
          hc_nxt    = c_hc;
          state_nxt = S_NBEV;
        end else if (dir_r == 3'd7) begin
          state_nxt = S_POPCHK;
        end else begin
          dir_nxt = dir_r + 1'b1;
        end
      end

      S_NBEV: begin
        if (st_q != ST_CLOSED && !blk_q) begin
          if (st_q == ST_NONE) begin
            st_we   = 1'b1; st_wa = nb_r; st_wd = ST_OPEN;
            node_we = 1'b1; node_wa = nb_r;
            node_wd = '{g: ng_r, f: c_nf, parent: best_cell_r, rank: rank_r};
            heap_we = 1'b1; heap_wa = cnt_r[CELL_W-1:0]; heap_wd = nb_r;
            cnt_nxt  = cnt_r + 1'b1;
            rank_nxt = rank_r + 1'b1;
          end else if (c_better) begin
            // decrease-key: rank kept
            node_we = 1'b1; node_wa = nb_r;
            node_wd = '{g: ng_r, f: c_nf, parent: best_cell_r, rank: node_q.rank};
          end
        end
        if (dir_r == 3'd7) begin
          state_nxt = S_POPCHK;
        end else begin
          dir_nxt   = dir_r + 1'b1;
          state_nxt = S_NBRD;
        end
      end

      // first walk: count path cells
      S_W1CHK: begin
        node_ra = p_r;
        if (p_r == start_cell || n_r == CNT_W'(CELLS)) begin
          wi_nxt    = n_r;
          p_nxt     = best_cell_r;
          state_nxt = S_W2PUT;
        end else begin
          state_nxt = S_W1GET;
        end
      end

      S_W1GET: begin
        p_nxt     = node_q.parent;
        n_nxt     = n_r + 1'b1;
        state_nxt = S_W1CHK;
      end

      // second walk: store cells from the goal back to index zero
      S_W2PUT: begin
        node_ra = p_r;
        path_we = 1'b1;
        path_wa = CELL_W'(wi_r - 1'b1);
        path_wd = p_r;
        if (wi_r == CNT_W'(1)) begin
          len_nxt   = n_r;
          found_nxt = 1'b1;
          state_nxt = S_RESP;
        end else begin
          wi_nxt    = wi_r - 1'b1;
          state_nxt = S_W2GET;
        end
      end

      S_W2GET: begin
        p_nxt     = node_q.parent;
        state_nxt = S_W2PUT;
      end

      S_RDWT: begin
        res_cell_nxt  = path_q;
        res_valid_nxt = 1'b1;
        state_nxt     = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_found_nxt   = found_r;
          o_len_nxt     = len_r;
          o_cell_nxt    = res_cell_r;
          o_ivalid_nxt  = res_valid_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sweep_r     <= '0;
      found_r     <= 1'b0;
      len_r       <= '0;
      cnt_r       <= '0;
      rank_r      <= '0;
      scan_i_r    <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      best_v_r    <= 1'b0;
      dir_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      found_r     <= found_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      rank_r      <= rank_nxt;
      scan_i_r    <= scan_i_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      best_v_r    <= best_v_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    zl_r <= zl_nxt; xh_r <= xh_nxt; zh_r <= zh_nxt;
    mx_r <= mx_nxt; mz_r <= mz_nxt; mval_r <= mval_nxt;
    sx_r <= sx_nxt; sz_r <= sz_nxt; gx_r <= gx_nxt; gz_r <= gz_nxt;
    s1_pos_r <= s1_pos_nxt; s2_pos_r <= s2_pos_nxt; s2_cell_r <= s2_cell_nxt;
    best_pos_r <= best_pos_nxt; best_cell_r <= best_cell_nxt;
    best_f_r <= best_f_nxt; best_g_r <= best_g_nxt; best_rank_r <= best_rank_nxt;
    nb_r <= nb_nxt; ng_r <= ng_nxt; hc_r <= hc_nxt;
    p_r <= p_nxt; n_r <= n_nxt; wi_r <= wi_nxt;
    res_cell_r <= res_cell_nxt; res_valid_r <= res_valid_nxt;
    o_found_r <= o_found_nxt; o_len_r <= o_len_nxt;
    o_cell_r <= o_cell_nxt; o_ivalid_r <= o_ivalid_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_path_found  = o_found_r;
  assign out_path_length = o_len_r;
  assign out_cell_x      = o_cell_r[COORD_W-1:0];
  assign out_cell_z      = o_cell_r[CELL_W-1:COORD_W];
  assign out_index_valid = o_ivalid_r;

  // open list never holds more than one entry per cell
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CELLS))
    else $error("open list count above cell count");

  // a pop always has a winner from the scan
  a_pop_best: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POPWR |-> best_v_r)
    else $error("pop without a selected entry");

  // a found path runs between two distinct cells
  a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_path_found |-> out_path_length >= 9'd2)
    else $error("found path shorter than two cells");

endmodule
`default_nettype wire
